// ===== src/pcb_pkg.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// pcb_pkg: shared types and constants
// Phase codes, status codes, register indexes and the controller/datapath
// command and status bundles of the pixel command parser.
// -----------------------------------------------------------------------------
package pcb_pkg;

    localparam logic [7:0] LINE_END    = 8'd10;
    localparam logic [7:0] FULL_ALPHA  = 8'd255;
    localparam logic [16:0] RECIP255   = 17'd65793;
    localparam logic [15:0] MAG_MAX    = 16'hFFFF;

    localparam logic [2:0] ST_WRITE  = 3'd0;
    localparam logic [2:0] ST_READ   = 3'd1;
    localparam logic [2:0] ST_OFFSET = 3'd2;
    localparam logic [2:0] ST_SIZE   = 3'd3;
    localparam logic [2:0] ST_ERROR  = 3'd4;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef enum logic [3:0] {
        PH_HEAD    = 4'd0,
        PH_PX_XS   = 4'd1,
        PH_PX_XD   = 4'd2,
        PH_PX_YS   = 4'd3,
        PH_PX_YD   = 4'd4,
        PH_PX_HEX  = 4'd5,
        PH_PX_TAIL = 4'd6,
        PH_OF_XW   = 4'd7,
        PH_OF_XS   = 4'd8,
        PH_OF_XD   = 4'd9,
        PH_OF_YW   = 4'd10,
        PH_OF_YS   = 4'd11,
        PH_OF_YD   = 4'd12,
        PH_OF_TAIL = 4'd13,
        PH_SIZE    = 4'd14,
        PH_ERR     = 4'd15
    } t_phase;

    // controller -> datapath
    typedef struct packed {
        logic       px_start;   // latch line, start pixel access
        logic       mem_rd;     // issue store read
        logic       blend_go;   // compute new color from read data
        logic       mem_wr;     // write blended color
        logic       res_load;   // load the non-pixel result
        logic [2:0] res_code;
        logic       px_done;    // load pixel result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic in_bounds;
        logic is_read;
        logic clr_busy;
    } t_stat;

endpackage
`default_nettype wire

// ===== src/pcb_datapath.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// pcb_datapath: parser registers, bounds check, frame store and blender
// Holds the per-line accumulators, the offsets, the frame store with its
// clearing pass, and the three-channel alpha blend.
// -----------------------------------------------------------------------------
module pcb_datapath #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_take,      // a non-newline byte accepted
    input  wire  [7:0]        i_char,
    input  wire  [8:0]        i_eff_w,
    input  wire  [8:0]        i_eff_h,
    input  wire  pcb_pkg::t_cmd i_cmd,
    output pcb_pkg::t_stat    o_stat,
    output pcb_pkg::t_phase   o_phase,
    output logic [2:0]        o_status,
    output logic [15:0]       o_x,
    output logic [15:0]       o_y,
    output logic [7:0]        o_r,
    output logic [7:0]        o_g,
    output logic [7:0]        o_b
);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    pcb_pkg::t_phase r_phase, n_phase;
    logic [16:0] r_ax, n_ax, r_ay, n_ay;
    logic [31:0] r_hex, n_hex;
    logic [3:0]  r_hcnt, n_hcnt;
    logic [1:0]  r_kw, n_kw;
    logic [2:0]  r_kpos, n_kpos;
    logic signed [16:0] r_sx, r_sy;

    // ------------------------------------------------------------- parser
    function automatic logic [16:0] acc_digit(input logic [16:0] a, input logic [7:0] c);
        logic [20:0] m;
        m = {1'b0, a[15:0], 3'd0} + {4'd0, a[15:0], 1'b0} + {17'd0, c[3:0]};
        return {a[16], (m > 21'd65535) ? pcb_pkg::MAG_MAX : m[15:0]};
    endfunction

    function automatic logic is_dig(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction
    function automatic logic is_spc(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
    endfunction
    function automatic logic is_sgn(input logic [7:0] c);
        return c == 8'h2D || c == 8'h2B;
    endfunction

    function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] p);
        logic [7:0] ch;
        ch = 8'h00;
        case (k)
            2'd0: case (p)
                3'd0: ch = "P"; 3'd1: ch = "X"; 3'd2: ch = " ";
                default: ch = 8'h00;
            endcase
            2'd1: case (p)
                3'd0: ch = "O"; 3'd1: ch = "F"; 3'd2: ch = "F"; 3'd3: ch = "S";
                3'd4: ch = "E"; 3'd5: ch = "T"; 3'd6: ch = " ";
                default: ch = 8'h00;
            endcase
            2'd2: case (p)
                3'd0: ch = "S"; 3'd1: ch = "I"; 3'd2: ch = "Z"; 3'd3: ch = "E";
                default: ch = 8'h00;
            endcase
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    logic       hv_ok;
    logic [3:0] hv;
    logic [1:0] kw_use;
    logic [2:0] kw_len;
    always_comb begin
        hv_ok = 1'b1;
        hv    = i_char[3:0];
        if (is_dig(i_char)) hv = i_char[3:0];
        else if ((i_char >= "a" && i_char <= "f") || (i_char >= "A" && i_char <= "F"))
            hv = i_char[3:0] + 4'd9;
        else hv_ok = 1'b0;
    end

    always_comb begin
        n_phase = r_phase; n_ax = r_ax; n_ay = r_ay; n_hex = r_hex;
        n_hcnt = r_hcnt; n_kw = r_kw; n_kpos = r_kpos;
        kw_use = r_kw; kw_len = 3'd3;
        case (r_phase)
            pcb_pkg::PH_HEAD: begin
                if (r_kpos == 3'd0) begin
                    if (i_char == "P") kw_use = 2'd0;
                    else if (i_char == "O") kw_use = 2'd1;
                    else kw_use = 2'd2;
                end
                case (kw_use)
                    2'd0: kw_len = 3'd3;
                    2'd1: kw_len = 3'd7;
                    default: kw_len = 3'd4;
                endcase
                n_kw = kw_use;
                if (i_char == kw_char(kw_use, r_kpos)) begin
                    n_kpos = r_kpos + 3'd1;
                    if (n_kpos == kw_len) begin
                        case (kw_use)
                            2'd0: n_phase = pcb_pkg::PH_PX_XS;
                            2'd1: n_phase = pcb_pkg::PH_OF_XW;
                            default: n_phase = pcb_pkg::PH_SIZE;
                        endcase
                    end
                end else n_phase = pcb_pkg::PH_ERR;
            end
            pcb_pkg::PH_PX_XS: begin
                if (i_char == "-") begin n_ax = 17'h10000; n_phase = pcb_pkg::PH_PX_XD; end
                else if (is_dig(i_char)) begin
                    n_ax = acc_digit(17'd0, i_char); n_phase = pcb_pkg::PH_PX_XD;
                end else n_phase = pcb_pkg::PH_ERR;
            end
            pcb_pkg::PH_PX_XD: begin
                if (is_dig(i_char)) n_ax = acc_digit(r_ax, i_char);
                else n_phase = pcb_pkg::PH_PX_YS;
            end
            pcb_pkg::PH_PX_YS: begin
                if (i_char == "-") begin n_ay = 17'h10000; n_phase = pcb_pkg::PH_PX_YD; end
                else if (is_dig(i_char)) begin
                    n_ay = acc_digit(17'd0, i_char); n_phase = pcb_pkg::PH_PX_YD;
                end else n_phase = pcb_pkg::PH_ERR;
            end
            pcb_pkg::PH_PX_YD: begin
                if (is_dig(i_char)) n_ay = acc_digit(r_ay, i_char);
                else n_phase = pcb_pkg::PH_PX_HEX;
            end
            pcb_pkg::PH_PX_HEX: begin
                if (hv_ok && r_hcnt < 4'd8) begin
                    n_hex = {r_hex[27:0], hv}; n_hcnt = r_hcnt + 4'd1;
                end else n_phase = pcb_pkg::PH_PX_TAIL;
            end
            pcb_pkg::PH_OF_XW, pcb_pkg::PH_OF_YW: begin
                if (is_spc(i_char)) begin
                end else if (is_sgn(i_char)) begin
                    if (r_phase == pcb_pkg::PH_OF_XW) begin
                        n_ax = {i_char == "-", 16'd0}; n_phase = pcb_pkg::PH_OF_XS;
                    end else begin
                        n_ay = {i_char == "-", 16'd0}; n_phase = pcb_pkg::PH_OF_YS;
                    end
                end else if (is_dig(i_char)) begin
                    if (r_phase == pcb_pkg::PH_OF_XW) begin
                        n_ax = acc_digit(17'd0, i_char); n_phase = pcb_pkg::PH_OF_XD;
                    end else begin
                        n_ay = acc_digit(17'd0, i_char); n_phase = pcb_pkg::PH_OF_YD;
                    end
                end else n_phase = pcb_pkg::PH_ERR;
            end
            pcb_pkg::PH_OF_XS: begin
                if (is_dig(i_char)) begin
                    n_ax = acc_digit(r_ax, i_char); n_phase = pcb_pkg::PH_OF_XD;
                end else n_phase = pcb_pkg::PH_ERR;
            end
            pcb_pkg::PH_OF_XD: begin
                if (is_dig(i_char)) n_ax = acc_digit(r_ax, i_char);
                else if (is_spc(i_char)) n_phase = pcb_pkg::PH_OF_YW;
                else if (is_sgn(i_char)) begin
                    n_ay = {i_char == "-", 16'd0}; n_phase = pcb_pkg::PH_OF_YS;
                end else n_phase = pcb_pkg::PH_ERR;
            end
            pcb_pkg::PH_OF_YS: begin
                if (is_dig(i_char)) begin
                    n_ay = acc_digit(r_ay, i_char); n_phase = pcb_pkg::PH_OF_YD;
                end else n_phase = pcb_pkg::PH_ERR;
            end
            pcb_pkg::PH_OF_YD: begin
                if (is_dig(i_char)) n_ay = acc_digit(r_ay, i_char);
                else n_phase = pcb_pkg::PH_OF_TAIL;
            end
            default: ;
        endcase
    end

    // signed value of an accumulator
    function automatic logic signed [17:0] acc_val(input logic [16:0] a);
        logic signed [17:0] m;
        m = $signed({2'b00, a[15:0]});
        return a[16] ? -m : m;
    endfunction

    logic signed [17:0] px, py;
    assign px = acc_val(r_ax) + 18'(r_sx);
    assign py = acc_val(r_ay) + 18'(r_sy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= pcb_pkg::PH_HEAD;
            r_ax <= '0; r_ay <= '0; r_hex <= '0; r_hcnt <= '0; r_kw <= '0; r_kpos <= '0;
            r_sx <= '0; r_sy <= '0;
        end else if (i_cmd.px_start || i_cmd.res_load) begin
            // line end: drop line state, and latch the offsets on an OFFSET result
            if (i_cmd.res_load && i_cmd.res_code == pcb_pkg::ST_OFFSET) begin
                r_sx <= 17'(acc_val(r_ax));
                r_sy <= 17'(acc_val(r_ay));
            end
            r_phase <= pcb_pkg::PH_HEAD;
            r_ax <= '0; r_ay <= '0; r_hex <= '0; r_hcnt <= '0; r_kw <= '0; r_kpos <= '0;
        end else if (i_take) begin
            r_phase <= n_phase; r_ax <= n_ax; r_ay <= n_ay; r_hex <= n_hex;
            r_hcnt <= n_hcnt; r_kw <= n_kw; r_kpos <= n_kpos;
        end
    end

    assign o_phase = r_phase;

    // ------------------------------------------------------- pixel access
    logic [15:0] r_lx, r_ly;
    logic [31:0] r_lhex;
    logic [3:0]  r_lcnt;
    logic        r_inb;
    logic [AW-1:0] r_addr;
    logic [17:0] prod;

    // the line accumulators are already cleared here, so use the latched row
    assign prod = {2'b0, r_ly} * {9'd0, i_eff_w};

    always_ff @(posedge i_clk) begin
        if (i_cmd.px_start) begin
            r_lx   <= px[15:0];
            r_ly   <= py[15:0];
            r_lhex <= r_hex;
            r_lcnt <= r_hcnt;
            r_inb  <= !px[17] && !py[17] && px < $signed({9'd0, i_eff_w})
                      && py < $signed({9'd0, i_eff_h});
        end
        if (i_cmd.mem_rd) r_addr <= AW'(prod + {2'b0, r_lx});
    end

    // frame store with clearing pass after reset
    logic [23:0] mem [DEPTH];
    logic [23:0] r_rdata;
    logic [AW:0] r_clr;
    logic        clr_busy;
    logic [23:0] wdata;
    assign clr_busy = !r_clr[AW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_clr <= '0;
        else if (clr_busy) r_clr <= r_clr + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (clr_busy) mem[r_clr[AW-1:0]] <= '0;
        else if (i_cmd.mem_wr) mem[r_addr] <= wdata;
        r_rdata <= mem[r_addr];
    end

    // blend: ((v*a + old*(255-a))*65793)>>24
    logic [7:0] nr, ng, nb, na;
    always_comb begin
        if (r_lcnt > 4'd6) begin
            nr = r_lhex[31:24]; ng = r_lhex[23:16]; nb = r_lhex[15:8]; na = r_lhex[7:0];
        end else if (r_lcnt > 4'd2) begin
            nr = r_lhex[23:16]; ng = r_lhex[15:8]; nb = r_lhex[7:0]; na = pcb_pkg::FULL_ALPHA;
        end else begin
            nr = r_lhex[7:0]; ng = r_lhex[7:0]; nb = r_lhex[7:0]; na = pcb_pkg::FULL_ALPHA;
        end
    end

    logic [16:0] r_sr, r_sg, r_sb;
    logic [7:0]  r_na;
    logic [7:0]  r_vr, r_vg, r_vb;
    function automatic logic [16:0] mix(input logic [7:0] v, input logic [7:0] o,
                                        input logic [7:0] a);
        return 17'({8'd0, v} * {8'd0, a}) + 17'({8'd0, o} * {8'd0, 8'd255 - a});
    endfunction
    function automatic logic [7:0] scale(input logic [16:0] s);
        logic [33:0] p;
        p = {17'd0, s} * {17'd0, pcb_pkg::RECIP255};
        return p[31:24];
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_cmd.blend_go) begin
            r_sr <= mix(nr, r_rdata[23:16], na);
            r_sg <= mix(ng, r_rdata[15:8], na);
            r_sb <= mix(nb, r_rdata[7:0], na);
            r_na <= na; r_vr <= nr; r_vg <= ng; r_vb <= nb;
        end
    end

    assign wdata = (r_na == pcb_pkg::FULL_ALPHA) ? {r_vr, r_vg, r_vb}
                 : {scale(r_sr), scale(r_sg), scale(r_sb)};

    // ----------------------------------------------------------- result
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            o_status <= i_cmd.res_code;
            o_x <= (i_cmd.res_code == pcb_pkg::ST_SIZE) ? {7'd0, i_eff_w} : 16'd0;
            o_y <= (i_cmd.res_code == pcb_pkg::ST_SIZE) ? {7'd0, i_eff_h} : 16'd0;
            o_r <= '0; o_g <= '0; o_b <= '0;
        end else if (i_cmd.px_done) begin
            if (!r_inb) begin
                o_status <= pcb_pkg::ST_ERROR;
                o_x <= '0; o_y <= '0; o_r <= '0; o_g <= '0; o_b <= '0;
            end else if (r_lcnt == 4'd0) begin
                o_status <= pcb_pkg::ST_READ;
                o_x <= r_lx; o_y <= r_ly;
                o_r <= r_rdata[23:16]; o_g <= r_rdata[15:8]; o_b <= r_rdata[7:0];
            end else begin
                o_status <= pcb_pkg::ST_WRITE;
                o_x <= r_lx; o_y <= r_ly;
                o_r <= '0; o_g <= '0; o_b <= '0;
            end
        end
    end

    assign o_stat.in_bounds = r_inb;
    assign o_stat.is_read   = (r_lcnt == 4'd0);
    assign o_stat.clr_busy  = clr_busy;

endmodule
`default_nettype wire

// ===== src/pcb_ctrl.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// pcb_ctrl: sequencer for line ends and the output register
// Accepts bytes, dispatches line-end work and runs the pixel
// read-modify-write sequence, then presents one result.
// -----------------------------------------------------------------------------
module pcb_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    input  wire  [7:0]        i_char,
    input  wire               i_out_ready,
    input  wire  pcb_pkg::t_phase i_phase,
    input  wire  pcb_pkg::t_stat  i_stat,
    output logic              o_in_ready,
    output logic              o_take,
    output logic              o_out_valid,
    output pcb_pkg::t_cmd     o_cmd
);
    typedef enum logic [2:0] {S_IDLE, S_ADDR, S_READ, S_BLEND, S_WRITE, S_DONE} t_state;
    t_state r_state;
    logic   r_ovalid;
    logic   acc, eol, out_free;

    assign out_free    = !r_ovalid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE) && !i_stat.clr_busy && out_free;
    assign acc         = i_in_valid && o_in_ready;
    assign eol         = acc && (i_char == pcb_pkg::LINE_END);
    assign o_take      = acc && !eol;
    assign o_out_valid = r_ovalid;

    logic px_line;
    assign px_line = i_phase == pcb_pkg::PH_PX_YD || i_phase == pcb_pkg::PH_PX_HEX
                  || i_phase == pcb_pkg::PH_PX_TAIL;

    always_comb begin
        o_cmd = '0;
        o_cmd.px_start = eol && px_line;
        o_cmd.res_load = eol && !px_line;
        case (i_phase)
            pcb_pkg::PH_OF_YD, pcb_pkg::PH_OF_TAIL: o_cmd.res_code = pcb_pkg::ST_OFFSET;
            pcb_pkg::PH_SIZE: o_cmd.res_code = pcb_pkg::ST_SIZE;
            default: o_cmd.res_code = pcb_pkg::ST_ERROR;
        endcase
        o_cmd.mem_rd   = (r_state == S_ADDR);
        o_cmd.blend_go = (r_state == S_BLEND);
        o_cmd.mem_wr   = (r_state == S_WRITE) && i_stat.in_bounds && !i_stat.is_read;
        o_cmd.px_done  = (r_state == S_DONE) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (o_cmd.res_load || o_cmd.px_done) r_ovalid <= 1'b1;
            else if (r_ovalid && i_out_ready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE:  if (o_cmd.px_start) r_state <= S_ADDR;
                S_ADDR:  r_state <= S_READ;
                S_READ:  r_state <= S_BLEND;   // read data registered
                S_BLEND: r_state <= S_WRITE;
                S_WRITE: r_state <= S_DONE;
                S_DONE:  if (out_free) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_take) else $error("byte taken during pixel access");
    a_no_take_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.clr_busy |-> !acc) else $error("byte taken while clearing");
    a_write_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.mem_wr |-> $past(r_state == S_BLEND)) else $error("write out of sequence");
    a_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.px_done |=> r_ovalid) else $error("pixel result lost");

endmodule
`default_nettype wire

// ===== src/pixel_command_parser_blender.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// pixel_command_parser_blender: text pixel command parser with alpha blend
//   channel    | direction | content
//   s_axis     | in        | tdata[7:0] char_in
//   m_axis     | out       | tdata status, coord_x, coord_y, red, green, blue
//   apb        | in        | frame_width @0, frame_height @4
// A byte other than newline is taken whenever s_tready is high. A newline on a PX line
// runs address, store read, registered read, blend, write and result steps in order.
// After reset a clearing pass over the frame store holds s_tready low. A stalled result
// holds the input until taken.
// -----------------------------------------------------------------------------
module pixel_command_parser_blender #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // [7:0] char_in
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [63:0] m_axis_tdata,   // status[2:0] coord_x[18:3] coord_y[34:19]
                                        // red[42:35] green[50:43] blue[58:51]
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [8:0] r_fw, r_fh, eff_w, eff_h;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw <= 9'd256; r_fh <= 9'd256;
        end else if (wr_en && paddr[1:0] == 2'd0) begin
            if (paddr[2] == pcb_pkg::REG_WIDTH) r_fw <= pwdata[8:0];
            else r_fh <= pwdata[8:0];
        end
    end
    assign prdata = {23'd0, (paddr[2] == pcb_pkg::REG_HEIGHT) ? r_fh : r_fw};

    assign eff_w = ({23'd0, r_fw} > MAX_WIDTH)  ? 9'(MAX_WIDTH)  : r_fw;
    assign eff_h = ({23'd0, r_fh} > MAX_HEIGHT) ? 9'(MAX_HEIGHT) : r_fh;

    pcb_pkg::t_cmd   cmd;
    pcb_pkg::t_stat  stat;
    pcb_pkg::t_phase phase;
    logic            take;
    logic [2:0]      st;
    logic [15:0]     cx, cy;
    logic [7:0]      cr, cg, cb;

    pcb_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(s_axis_tvalid),
        .i_char(s_axis_tdata), .i_out_ready(m_axis_tready), .i_phase(phase),
        .i_stat(stat), .o_in_ready(s_axis_tready), .o_take(take),
        .o_out_valid(m_axis_tvalid), .o_cmd(cmd)
    );

    pcb_datapath #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_take(take), .i_char(s_axis_tdata),
        .i_eff_w(eff_w), .i_eff_h(eff_h), .i_cmd(cmd), .o_stat(stat),
        .o_phase(phase), .o_status(st), .o_x(cx), .o_y(cy),
        .o_r(cr), .o_g(cg), .o_b(cb)
    );

    assign m_axis_tdata = {5'd0, cb, cg, cr, cy, cx, st};

endmodule
`default_nettype wire
